// ===== rtl/core/bs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bs_pkg;

  // Width of one value and of the size register.
  localparam int unsigned DataW = 32;
  localparam int unsigned CfgW  = 3;

  // The size register comes out of reset asking for the largest load.
  localparam logic [CfgW-1:0] CfgReset = 3'd6;

  // Smallest legal load is two values.
  localparam logic [CfgW-1:0] CfgMinLog2 = 3'd1;

  typedef logic signed [DataW-1:0] data_t;

endpackage

`default_nettype wire

// ===== rtl/core/bs_stream_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Input stream: one value to be sorted per request.
interface bs_in_if;
  logic                    valid;
  logic                    ready;
  logic signed [32-1:0]    value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

// Output stream: one sorted value per request, last marks the end of a sort.
interface bs_out_if;
  logic                    valid;
  logic                    ready;
  logic signed [32-1:0]    sorted_value;
  logic                    last;

  modport source (output valid, output sorted_value, output last, input ready);
  modport sink   (input valid, input sorted_value, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/bs_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bs_store #(
  parameter int unsigned AddrW = 6
) (
  input  wire                 clk_i,
  input  wire                 we_i,
  input  wire [AddrW-1:0]     waddr_i,
  input  wire bs_pkg::data_t  wdata_i,
  input  wire [AddrW-1:0]     raddr_a_i,
  input  wire [AddrW-1:0]     raddr_b_i,
  output bs_pkg::data_t       rdata_a_o,
  output bs_pkg::data_t       rdata_b_o
);
  import bs_pkg::*;

  localparam int unsigned Depth = 1 << AddrW;

  data_t mem_q [Depth];
  data_t rdata_a_q;
  data_t rdata_b_q;

  // One write port and two registered read ports.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_q <= mem_q[raddr_a_i];
    rdata_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

`default_nettype wire

// ===== rtl/core/bs_cex.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bs_cex (
  input  wire bs_pkg::data_t  a_i,
  input  wire bs_pkg::data_t  b_i,
  input  wire                 asc_i,
  output bs_pkg::data_t       first_o,
  output bs_pkg::data_t       second_o
);
  import bs_pkg::*;

  logic swap;

  // Swap when the pair is out of order for the requested direction.
  always_comb begin
    if (asc_i) begin
      swap = (a_i > b_i);
    end else begin
      swap = (a_i < b_i);
    end
  end

  assign first_o  = swap ? b_i : a_i;
  assign second_o = swap ? a_i : b_i;

endmodule

`default_nettype wire

// ===== rtl/core/bitonic_sorter.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Bitonic sorter. Load 2^count_log2 signed 32-bit values on the input stream
// (count_log2 is taken as 1 when zero and is capped at the largest load that
// MAX_VALUES allows); after the last value of a load the block sorts them in
// place with a bitonic compare-exchange network and streams them out in
// ascending order, with last set on the final value. A write of the size
// register drops any partly loaded values. Input values are taken one per
// cycle. Sorting runs on one comparator against a store with two read ports
// and one write port: each compare-exchange reads its pair (S_RD), then
// compares and writes back the first value (S_CX), holding the second in a
// pending register that is written during the following read or in the
// flush state (S_FL) ending each network step. Emitting reads each value
// (S_EA) and moves it to the output register (S_EB), waiting while the
// output is stalled. The input is not ready while sorting or emitting.
module bitonic_sorter #(
  parameter int unsigned MAX_VALUES = 64
) (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      cfg_we_i,
  input  wire [bs_pkg::CfgW-1:0]   cfg_data_i,
  bs_in_if.sink                    in_i,
  bs_out_if.source                 out_o
);
  import bs_pkg::*;

  // Largest usable load is the biggest power of two within MAX_VALUES.
  localparam int unsigned MaxLog2 = $clog2(MAX_VALUES + 1) - 1;
  localparam int unsigned AddrW   = MaxLog2;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD,
    S_CX,
    S_FL,
    S_EA,
    S_EB
  } state_e;

  state_e             state_q;
  logic [CfgW-1:0]    cfg_q;
  logic [AddrW-1:0]   load_cnt_q;
  logic [CfgW-1:0]    stage_q;
  logic [CfgW-1:0]    step_q;
  logic [AddrW-1:0]   pair_q;
  logic [AddrW-1:0]   emit_q;
  logic               pend_q;
  logic [AddrW-1:0]   pend_addr_q;
  data_t              pend_data_q;
  logic               out_valid_q;
  data_t              out_value_q;
  logic               out_last_q;

  logic [CfgW-1:0]    lg;
  logic [AddrW:0]     n_full;
  logic [AddrW-1:0]   n_m1;
  logic [AddrW-1:0]   pair_last;
  logic [AddrW-1:0]   bit_t;
  logic [AddrW-1:0]   low_mask;
  logic [AddrW-1:0]   idx_i;
  logic [AddrW-1:0]   idx_p;
  logic [AddrW:0]     idx_shift;
  logic               asc;
  logic               in_fire;
  logic               out_free;

  logic               mem_we;
  logic [AddrW-1:0]   mem_waddr;
  data_t              mem_wdata;
  logic [AddrW-1:0]   mem_raddr_a;
  data_t              rdata_a;
  data_t              rdata_b;
  data_t              cex_first;
  data_t              cex_second;

  // Effective load size from the size register.
  always_comb begin
    lg = cfg_q;
    if (lg < CfgMinLog2) begin
      lg = CfgMinLog2;
    end
    if (lg > CfgW'(MaxLog2)) begin
      lg = CfgW'(MaxLog2);
    end
  end

  assign n_full    = (AddrW+1)'(1) << lg;
  assign n_m1      = AddrW'(n_full - (AddrW+1)'(1));
  assign pair_last = n_m1 >> 1;

  // Pair addresses: insert a zero at bit step into the pair counter.
  assign bit_t     = AddrW'(1) << step_q;
  assign low_mask  = bit_t - AddrW'(1);
  assign idx_i     = AddrW'({pair_q & ~low_mask, 1'b0}) | (pair_q & low_mask);
  assign idx_p     = idx_i | bit_t;
  assign idx_shift = {1'b0, idx_i} >> stage_q;
  assign asc       = ~idx_shift[0];

  assign in_i.ready = (state_q == S_LOAD);
  assign in_fire    = in_i.valid && (state_q == S_LOAD);
  assign out_free   = !out_valid_q || out_o.ready;

  // Store write port: loading, pending second element, or first element.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = load_cnt_q;
    mem_wdata = in_i.value;
    unique case (state_q)
      S_LOAD: begin
        mem_we = in_fire;
      end
      S_RD, S_FL: begin
        mem_we    = pend_q;
        mem_waddr = pend_addr_q;
        mem_wdata = pend_data_q;
      end
      S_CX: begin
        mem_we    = 1'b1;
        mem_waddr = idx_i;
        mem_wdata = cex_first;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_raddr_a = (state_q == S_EA || state_q == S_EB) ? emit_q : idx_i;

  bs_store #(
    .AddrW (AddrW)
  ) u_store (
    .clk_i     (clk_i),
    .we_i      (mem_we),
    .waddr_i   (mem_waddr),
    .wdata_i   (mem_wdata),
    .raddr_a_i (mem_raddr_a),
    .raddr_b_i (idx_p),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  bs_cex u_cex (
    .a_i      (rdata_a),
    .b_i      (rdata_b),
    .asc_i    (asc),
    .first_o  (cex_first),
    .second_o (cex_second)
  );

  // Sequencer: load, sort network, emit; also holds the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      cfg_q       <= CfgReset;
      load_cnt_q  <= '0;
      stage_q     <= '0;
      step_q      <= '0;
      pair_q      <= '0;
      emit_q      <= '0;
      pend_q      <= 1'b0;
      pend_addr_q <= '0;
      pend_data_q <= '0;
      out_valid_q <= 1'b0;
      out_value_q <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // The output register empties unless a new value replaces the taken one.
      if (out_valid_q && out_o.ready && !(state_q == S_EB && out_free)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_LOAD: begin
          if (cfg_we_i) begin
            cfg_q      <= cfg_data_i;
            load_cnt_q <= '0;
          end else if (in_fire) begin
            if (load_cnt_q == n_m1) begin
              load_cnt_q <= '0;
              stage_q    <= CfgW'(1);
              step_q     <= '0;
              pair_q     <= '0;
              pend_q     <= 1'b0;
              state_q    <= S_RD;
            end else begin
              load_cnt_q <= load_cnt_q + AddrW'(1);
            end
          end
        end
        S_RD: begin
          pend_q  <= 1'b0;
          state_q <= S_CX;
        end
        S_CX: begin
          pend_q      <= 1'b1;
          pend_addr_q <= idx_p;
          pend_data_q <= cex_second;
          if (pair_q == pair_last) begin
            state_q <= S_FL;
          end else begin
            pair_q  <= pair_q + AddrW'(1);
            state_q <= S_RD;
          end
        end
        S_FL: begin
          pend_q <= 1'b0;
          pair_q <= '0;
          if (step_q != '0) begin
            step_q  <= step_q - CfgW'(1);
            state_q <= S_RD;
          end else if (stage_q == lg) begin
            stage_q <= '0;
            emit_q  <= '0;
            state_q <= S_EA;
          end else begin
            step_q  <= stage_q;
            stage_q <= stage_q + CfgW'(1);
            state_q <= S_RD;
          end
        end
        S_EA: begin
          state_q <= S_EB;
        end
        S_EB: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_value_q <= rdata_a;
            out_last_q  <= (emit_q == n_m1);
            if (emit_q == n_m1) begin
              emit_q  <= '0;
              state_q <= S_LOAD;
            end else begin
              emit_q  <= emit_q + AddrW'(1);
              state_q <= S_EA;
            end
          end
        end
        default: begin
          state_q <= S_LOAD;
        end
      endcase
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_value_q;
  assign out_o.last         = out_last_q;

  // A pending second write only survives into the cycle that retires it.
  a_pend_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_RD || state_q == S_FL))
    else $error("pending write outside read or flush");

  // While sorting, the step stays below its stage and the stage within the load.
  a_sort_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RD || state_q == S_CX || state_q == S_FL) |->
      (step_q < stage_q && stage_q <= lg && stage_q != '0))
    else $error("sort counters out of range");

  // The final value of a load starts the network with an empty load counter.
  a_load_to_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !cfg_we_i && load_cnt_q == n_m1) |=>
      (state_q == S_RD && load_cnt_q == '0 && !pend_q))
    else $error("completed load did not start the sort");

  // The store is not written while sorted values are being emitted.
  a_no_write_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EA || state_q == S_EB) |-> !mem_we)
    else $error("store written during emit");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import bs_pkg::*;

  localparam int unsigned MaxValues    = 64;
  // Results come back in a whole burst only after the last value of a load.
  // Wait this long before touching the size register once all have arrived.
  localparam int unsigned SettleCycles = 64;
  localparam int unsigned RandomItems  = 290;
  // The slowest correct run is about 390 values, each sorted, emitted into a
  // stalling receiver and sent after random gaps, plus the settle pauses.
  // This limit leaves plenty of margin for it.
  localparam int unsigned CycleLimit   = 200000;

  localparam data_t DataMin = 32'sh8000_0000;
  localparam data_t DataMax = 32'sh7fff_ffff;

  typedef struct packed {
    data_t sorted_value;
    logic  last;
  } result_t;

  // One row of the directed table: either a size register write or one
  // request. Rows with a typed result complete a two-value load.
  typedef struct packed {
    logic            set_size;
    logic [CfgW-1:0] size;
    data_t           value;
    logic            typed;
    data_t           lo;
    data_t           hi;
  } row_t;

  logic            clk_i;
  logic            rst_ni;
  logic            cfg_we_i;
  logic [CfgW-1:0] cfg_data_i;

  bs_in_if  in_if ();
  bs_out_if out_if ();

  bitonic_sorter #(
    .MAX_VALUES(MaxValues)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_data_i(cfg_data_i),
    .in_i      (in_if),
    .out_o     (out_if)
  );

  // Shadow of the block: size register, partly loaded values and fill level.
  logic [CfgW-1:0] size_reg;
  data_t           load_buf [MaxValues];
  int unsigned     load_fill;

  result_t         sorted_q [$];
  result_t         head;
  int unsigned     mismatches;
  int unsigned     cycle_count;
  int unsigned     burst_left;
  logic [1:0]      stall_mode;

  row_t directed_rows [21] = '{
    '{1'b1, 3'd1, 32'sd0,   1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, DataMax,  1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, DataMin,  1'b1, DataMin,  DataMax},
    '{1'b0, 3'd0, DataMin,  1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, DataMax,  1'b1, DataMin,  DataMax},
    '{1'b0, 3'd0, -32'sd1,  1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, 32'sd0,   1'b1, -32'sd1,  32'sd0},
    '{1'b0, 3'd0, 32'sd0,   1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, -32'sd1,  1'b1, -32'sd1,  32'sd0},
    '{1'b0, 3'd0, 32'sd5,   1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, 32'sd5,   1'b1, 32'sd5,   32'sd5},
    '{1'b0, 3'd0, 32'sd1,   1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, -32'sd2,  1'b1, -32'sd2,  32'sd1},
    // A size of zero is taken as two values.
    '{1'b1, 3'd0, 32'sd0,   1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, 32'sd3,   1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, -32'sd3,  1'b1, -32'sd3,  32'sd3},
    '{1'b1, 3'd2, 32'sd0,   1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, DataMax,  1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, 32'sd0,   1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, DataMin,  1'b0, 32'sd0,   32'sd0},
    '{1'b0, 3'd0, -32'sd1,  1'b0, 32'sd0,   32'sd0}
  };

  // Every size code once, extremes included, before random sizes take over.
  logic [CfgW-1:0] size_order [8] = '{3'd7, 3'd3, 3'd0, 3'd5, 3'd1, 3'd6, 3'd4, 3'd2};

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  task automatic report_mismatch(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Effective log2 of the load size: zero means two values, and the size is
  // capped at six and at what MAX_VALUES allows.
  function automatic int unsigned load_log2(logic [CfgW-1:0] code);
    int unsigned lg;
    lg = code;
    if (lg < CfgMinLog2) lg = CfgMinLog2;
    if (lg > 6) lg = 6;
    while (lg > 1 && (1 << lg) > MaxValues) lg--;
    return lg;
  endfunction

  // Bitonic compare-exchange network over the loaded values. In each stage
  // the pair direction comes from the stage bit of the lower index.
  task automatic bitonic_network(int unsigned lg);
    int    n;
    int    stage;
    int    t;
    int    i;
    int    p;
    bit    up;
    data_t a;
    data_t b;
    n = 1 << lg;
    for (stage = 1; stage <= lg; stage++) begin
      for (t = stage - 1; t >= 0; t--) begin
        for (i = 0; i < n; i++) begin
          p = i ^ (1 << t);
          if (p > i) begin
            up = ((i >> stage) & 1) == 0;
            a  = load_buf[i];
            b  = load_buf[p];
            if (up ? (a > b) : (a < b)) begin
              load_buf[i] = b;
              load_buf[p] = a;
            end
          end
        end
      end
    end
  endtask

  // Store one accepted value; a completing value sorts the load and queues
  // the ascending sequence, or the typed pair where the row gives one.
  task automatic load_value(data_t v, logic typed, data_t lo, data_t hi);
    int unsigned lg;
    int unsigned n;
    lg = load_log2(size_reg);
    n  = 1 << lg;
    if (load_fill >= n) load_fill = 0;
    load_buf[load_fill] = v;
    load_fill++;
    if (load_fill == n) begin
      bitonic_network(lg);
      if (typed) begin
        sorted_q.push_back('{lo, 1'b0});
        sorted_q.push_back('{hi, 1'b1});
      end else begin
        for (int k = 0; k < n; k++) sorted_q.push_back('{load_buf[k], k == n - 1});
      end
      load_fill = 0;
    end
  endtask

  // Send one request. The sender runs in bursts with random gaps between
  // them; valid stays high across back-to-back requests.
  task automatic send_value(data_t v, logic typed, data_t lo, data_t hi);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
      if (gap != 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk_i); while (!in_if.ready);
    burst_left--;
    load_value(v, typed, lo, hi);
  endtask

  // Size writes happen only with the block idle: every result back, then a
  // settle pause.
  task automatic write_size(logic [CfgW-1:0] code);
    in_if.valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= code;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    size_reg   = code;
    load_fill  = 0;
    burst_left = 0;
  endtask

  // Full-range values half the time, else extremes or a narrow band for ties.
  function automatic data_t pick_value();
    case ($urandom_range(0, 7))
      0:       return DataMin;
      1:       return DataMax;
      2, 3:    return data_t'($urandom_range(0, 7)) - 32'sd4;
      default: return data_t'($urandom);
    endcase
  endfunction

  // Output check plus the receiver's own stall pattern, drawn from four modes.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (sorted_q.size() == 0) begin
        report_mismatch($sformatf("unexpected value %0d last %0b",
                                  out_if.sorted_value, out_if.last));
      end else begin
        head = sorted_q.pop_front();
        if (out_if.sorted_value !== head.sorted_value)
          report_mismatch($sformatf("sorted_value %0d, want %0d",
                                    out_if.sorted_value, head.sorted_value));
        if (out_if.last !== head.last)
          report_mismatch($sformatf("last %0b, want %0b", out_if.last, head.last));
      end
    end
    if (cycle_count % 256 == 0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_if.ready <= 1'b1;
      2'd1: out_if.ready <= ($urandom_range(0, 3) != 0);
      2'd2: out_if.ready <= ~out_if.ready;
      default: out_if.ready <= (cycle_count[1:0] == 2'd0);
    endcase
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("bitonic_sorter: mismatch");
      $finish;
    end
  end

  initial begin
    int unsigned sent;
    int unsigned phase;
    int unsigned n;
    int unsigned loads;
    logic [CfgW-1:0] code;

    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_data_i   = '0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    out_if.ready = 1'b0;
    stall_mode   = 2'd0;
    cycle_count  = 0;
    mismatches   = 0;
    burst_left   = 0;
    size_reg     = CfgReset;
    load_fill    = 0;

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Power-on size: one full load as a strictly descending ramp across zero.
    for (int k = 0; k < MaxValues; k++) send_value(DataMax - data_t'(k << 26), 1'b0, '0, '0);

    foreach (directed_rows[r]) begin
      if (directed_rows[r].set_size) begin
        write_size(directed_rows[r].size);
      end else begin
        send_value(directed_rows[r].value, directed_rows[r].typed,
                   directed_rows[r].lo, directed_rows[r].hi);
      end
    end

    // Random loads; large sizes get a single load, small ones up to eight.
    sent  = 0;
    phase = 0;
    while (sent < RandomItems) begin
      code = (phase < 8) ? size_order[phase] : 3'($urandom_range(0, 4));
      write_size(code);
      n = 1 << load_log2(code);
      loads = (n <= 8) ? $urandom_range(1, 8) : ((n <= 16) ? $urandom_range(1, 2) : 1);
      repeat (loads * n) begin
        send_value(pick_value(), 1'b0, '0, '0);
        sent++;
      end
      phase++;
    end

    in_if.valid <= 1'b0;
    while (sorted_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("bitonic_sorter: match");
    end else begin
      $display("bitonic_sorter: mismatch");
    end
    $finish;
  end

endmodule
